[hdl/swm_pkg.sv]
// Package for the sliding window maximum filter.
// Holds the cell record, the per-cycle control record and fixed field widths.
// No dependencies.
package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int WSIZE_W  = 7;
  localparam int AGE_W    = WSIZE_W;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [AGE_W-1:0]           age;
    logic                       valid;
  } cell_t;

  typedef struct packed {
    logic                       step;
    logic                       cleanup;
    logic                       restart;
    logic                       shift;
    logic signed [SAMPLE_W-1:0] sample;
    logic [AGE_W-1:0]           k;
  } ctrl_t;

endpackage

[hdl/swm_cell.sv]
// One cell of the candidate queue: a value, its age in samples and a valid bit.
// Takes data from its newer-side neighbor on a shift. Depends on swm_pkg.
module swm_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  swm_pkg::ctrl_t ctrl_i,
  input  swm_pkg::cell_t next_i,
  input  logic          next_surv_i,
  input  logic          prev_src_surv_i,
  output swm_pkg::cell_t cell_o,
  output logic          surv_o,
  output logic          src_surv_o
);
  import swm_pkg::*;

  logic                       valid_q, valid_d;
  logic signed [SAMPLE_W-1:0] value_q, value_d;
  logic [AGE_W-1:0]           age_q, age_d;
  logic                       own_surv;
  logic                       src_surv;
  cell_t                      src;

  always_comb begin
    own_surv = valid_q & ~ctrl_i.restart & (age_q < ctrl_i.k) & (value_q > ctrl_i.sample);
    src      = ctrl_i.shift ? next_i : cell_o;
    src_surv = ctrl_i.shift ? next_surv_i : own_surv;
    valid_d  = valid_q;
    value_d  = value_q;
    age_d    = age_q;
    if (ctrl_i.cleanup) begin
      valid_d = next_i.valid;
      value_d = next_i.value;
      age_d   = next_i.age;
    end else if (ctrl_i.step) begin
      if (src_surv) begin
        valid_d = 1'b1;
        value_d = src.value;
        age_d   = src.age + AGE_W'(1);
      end else if (prev_src_surv_i) begin
        valid_d = 1'b1;
        value_d = ctrl_i.sample;
        age_d   = AGE_W'(1);
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    age_q   <= age_d;
  end

  assign cell_o.value = value_q;
  assign cell_o.age   = age_q;
  assign cell_o.valid = valid_q;
  assign surv_o       = own_surv;
  assign src_surv_o   = src_surv;

endmodule

[hdl/sliding_window_maximum.sv]
// Top level of the sliding window maximum filter: a row of queue cells,
// the sequence counter, the window size register and a two-entry result buffer.
// Depends on swm_pkg and swm_cell.
//
//   Port group        Direction  Handshake                  Payload
//   input request     in         in_valid_i / in_stall_o    sample_i, start_sequence_i
//   result request    out        out_valid_o / out_stall_i  window_max_o
//   window size       in         window_size_we_i           window_size_i
//
// One request is taken per cycle unless the input stalls; its result is registered in the output or skid entry.
// All cells compare against the new sample in parallel and shift by at most one place.
// After the window size shrinks, surplus aged entries are shifted out one at a time by cleanup, stalling input.
// Reset empties the queue at once and sets the window size to 1; no clearing pass.
// Two buffered results stall the input until the output side takes one.
module sliding_window_maximum #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                start_sequence_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [swm_pkg::SAMPLE_W-1:0] window_max_o,
  input  logic                                window_size_we_i,
  input  logic [swm_pkg::WSIZE_W-1:0]         window_size_i
);
  import swm_pkg::*;

  localparam int SEEN_W = $clog2(WINDOW_MAX + 1);

  logic [WSIZE_W-1:0]         window_size_q;
  logic [AGE_W-1:0]           k_eff;
  logic [SEEN_W-1:0]          seen_q, seen_d;
  logic                       accept, cleanup, shift, push, pop, has_result;
  logic signed [SAMPLE_W-1:0] result;
  ctrl_t                      ctrl;
  cell_t                      cells [WINDOW_MAX+1];
  logic                       surv [WINDOW_MAX+1];
  logic                       src_surv [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]      valid_vec;

  logic                       out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic signed [SAMPLE_W-1:0] out_data_q, out_data_d, skid_data_q, skid_data_d;

  always_comb begin
    if (window_size_q == '0) begin
      k_eff = AGE_W'(1);
    end else if (32'(window_size_q) > WINDOW_MAX) begin
      k_eff = AGE_W'(WINDOW_MAX);
    end else begin
      k_eff = window_size_q;
    end
  end

  assign cleanup    = cells[1].valid & (cells[1].age >= k_eff);
  assign in_stall_o = cleanup | skid_valid_q;
  assign accept     = in_valid_i & ~in_stall_o;
  assign shift      = accept & ~start_sequence_i & cells[0].valid & (cells[0].age >= k_eff);

  assign ctrl.step    = accept;
  assign ctrl.cleanup = cleanup;
  assign ctrl.restart = start_sequence_i;
  assign ctrl.shift   = shift;
  assign ctrl.sample  = sample_i;
  assign ctrl.k       = k_eff;

  assign cells[WINDOW_MAX] = '{value: '0, age: '0, valid: 1'b0};
  assign surv[WINDOW_MAX]  = 1'b0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic prev_src_surv;
    if (i == 0) begin : g_head
      assign prev_src_surv = 1'b1;
    end else begin : g_body
      assign prev_src_surv = src_surv[i-1];
    end
    swm_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .next_i         (cells[i+1]),
      .next_surv_i    (surv[i+1]),
      .prev_src_surv_i(prev_src_surv),
      .cell_o         (cells[i]),
      .surv_o         (surv[i]),
      .src_surv_o     (src_surv[i])
    );
    assign valid_vec[i] = cells[i].valid;
  end

  always_comb begin
    if (start_sequence_i) begin
      seen_d = SEEN_W'(1);
    end else if (32'(seen_q) >= WINDOW_MAX) begin
      seen_d = seen_q;
    end else begin
      seen_d = seen_q + SEEN_W'(1);
    end
    has_result = 32'(seen_d) >= 32'(k_eff);
    if (!src_surv[0]) begin
      result = sample_i;
    end else if (shift) begin
      result = cells[1].value;
    end else begin
      result = cells[0].value;
    end
  end

  assign push = accept & has_result;
  assign pop  = out_valid_q & ~out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = push;
        skid_data_d  = result;
      end else begin
        out_valid_d = push;
        out_data_d  = result;
      end
    end else if (push) begin
      if (out_valid_q) begin
        skid_valid_d = 1'b1;
        skid_data_d  = result;
      end else begin
        out_valid_d = 1'b1;
        out_data_d  = result;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WSIZE_W'(1);
      seen_q        <= '0;
      out_valid_q   <= 1'b0;
      skid_valid_q  <= 1'b0;
    end else begin
      if (window_size_we_i) begin
        window_size_q <= window_size_i;
      end
      if (accept) begin
        seen_q <= seen_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o  = out_valid_q;
  assign window_max_o = out_data_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_front_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> cells[0].valid)
    else $error("queue front empty after a request");

  a_no_cleanup_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !window_size_we_i) |=> !cleanup)
    else $error("more than one aged entry after a request");

  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + WINDOW_MAX'(1))) == '0)
    else $error("occupied cells are not packed at the front");

endmodule
